@@ design/led_matrix_frame_packer_macros.svh @@
// Assertion macros shared by the checker of the LED matrix frame packer.
// Each macro expands to one labelled concurrent assertion on clk, held off by rst.
`ifndef LED_MATRIX_FRAME_PACKER_MACROS_SVH
`define LED_MATRIX_FRAME_PACKER_MACROS_SVH

// Same-cycle implication.
`define LMFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmfp assertion failed");

// Next-cycle implication.
`define LMFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmfp assertion failed");

`endif

@@ design/lmfp_pkg.sv @@
// Package of the LED matrix frame packer: sizes, action and state codes,
// and the row coding function. Depends on nothing.
`default_nettype none

package lmfp_pkg;

  localparam int ROWS      = 7;
  localparam int ROW_W     = 21;
  localparam int IDX_W     = 3;
  localparam int ACT_W     = 2;
  localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LEVEL_W   = 2;
  localparam int CODE_W    = 24;
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 56;
  localparam int M_USED_W  = LEVEL_W + IDX_W + 2 * CODE_W;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL     = 2'd2;
  localparam logic [IDX_W-1:0]   LAST_PAIR_ROW = 3'd6;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INVERT = 2'd1,
    ACT_LOAD   = 2'd2,
    ACT_UPDATE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_GET_FIRST,
    ST_GET_SECOND,
    ST_INV_RD,
    ST_INV_WR
  } state_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = b[i];
    end
    return r;
  endfunction

  // Returns {high, mid, low} message bytes of one row, active low and bit-reversed.
  function automatic logic [CODE_W-1:0] code_row(input logic [ROW_W-1:0] bits);
    logic [ROW_W-1:0] inv;
    inv = ~bits;
    return {rev8(inv[20:13]), rev8(inv[12:5]), rev8({inv[4:0], 3'b111})};
  endfunction

endpackage

`default_nettype wire

@@ design/led_matrix_frame_packer.sv @@
// LED matrix frame packer: clear, invert, load and update of a 7 x 21 bit frame.
// Clear and load are done as the command is taken; invert reads and then writes back each row in turn.
// Update: each of the four messages passes ST_RD_FIRST, ST_GET_FIRST and ST_GET_SECOND through
// the single row read port and coder, and ST_GET_SECOND waits while the output is held by tready.
// Reset (rst, synchronous): frame reads as all off, brightness 2, no message pending.
`default_nettype none

module led_matrix_frame_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lmfp_pkg::LEVEL_W-1:0]  cfg_wr_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // row_index[2:0], row_bits[23:3]
  input  logic [lmfp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action[1:0]
  input  logic [lmfp_pkg::ACT_W-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // level_byte[1:0], pair_row[4:2], first_low_byte, first_mid_byte, first_high_byte,
  // second_low_byte, second_mid_byte, second_high_byte (8 bits each from bit 5), zero fill
  output logic [lmfp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  lmfp_pkg::state_t state, state_next;

  logic [lmfp_pkg::IDX_W-1:0]   cnt, cnt_next;
  logic [lmfp_pkg::LEVEL_W-1:0] brightness;
  logic [lmfp_pkg::ROWS-1:0]    row_valid;
  logic [lmfp_pkg::ROW_W-1:0]   mem [lmfp_pkg::ROWS];
  logic [lmfp_pkg::ROW_W-1:0]   rd_data;
  logic                         rd_ok;
  logic [lmfp_pkg::CODE_W-1:0]  first_code;

  lmfp_pkg::action_t            in_action;
  logic [lmfp_pkg::IDX_W-1:0]   in_row_index;
  logic [lmfp_pkg::ROW_W-1:0]   in_row_bits;
  logic                         s_accept;
  logic                         out_free;
  logic                         is_last_pair;

  logic [lmfp_pkg::IDX_W-1:0]   rd_addr;
  logic                         mem_we;
  logic [lmfp_pkg::IDX_W-1:0]   mem_wa;
  logic [lmfp_pkg::ROW_W-1:0]   mem_wd;
  logic                         valid_clr;
  logic                         capture_first;
  logic                         out_load;

  logic [lmfp_pkg::ROW_W-1:0]   row_val;
  logic [lmfp_pkg::CODE_W-1:0]  coded;
  logic [lmfp_pkg::CODE_W-1:0]  second_code;

  assign in_action    = lmfp_pkg::action_t'(s_axis_tuser);
  assign in_row_index = s_axis_tdata[2:0];
  assign in_row_bits  = s_axis_tdata[23:3];
  assign s_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free     = !m_axis_tvalid || m_axis_tready;
  assign is_last_pair = (cnt == lmfp_pkg::LAST_PAIR_ROW);

  // A row that was never written since the last clear reads as all off.
  assign row_val     = rd_ok ? rd_data : '0;
  assign coded       = lmfp_pkg::code_row(row_val);
  assign second_code = is_last_pair ? '0 : coded;

  always_comb begin
    state_next = state;
    case (state)
      lmfp_pkg::ST_IDLE: begin
        if (s_accept) begin
          if (in_action == lmfp_pkg::ACT_UPDATE) begin
            state_next = lmfp_pkg::ST_RD_FIRST;
          end else if (in_action == lmfp_pkg::ACT_INVERT) begin
            state_next = lmfp_pkg::ST_INV_RD;
          end
        end
      end
      lmfp_pkg::ST_RD_FIRST:  state_next = lmfp_pkg::ST_GET_FIRST;
      lmfp_pkg::ST_GET_FIRST: state_next = lmfp_pkg::ST_GET_SECOND;
      lmfp_pkg::ST_GET_SECOND: begin
        if (out_free) begin
          state_next = is_last_pair ? lmfp_pkg::ST_IDLE : lmfp_pkg::ST_RD_FIRST;
        end
      end
      lmfp_pkg::ST_INV_RD: state_next = lmfp_pkg::ST_INV_WR;
      lmfp_pkg::ST_INV_WR: begin
        if (cnt == lmfp_pkg::IDX_W'(lmfp_pkg::ROWS - 1)) begin
          state_next = lmfp_pkg::ST_IDLE;
        end else begin
          state_next = lmfp_pkg::ST_INV_RD;
        end
      end
      default: state_next = lmfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cnt_next      = cnt;
    rd_addr       = cnt;
    mem_we        = 1'b0;
    mem_wa        = cnt;
    mem_wd        = ~row_val;
    valid_clr     = 1'b0;
    capture_first = 1'b0;
    out_load      = 1'b0;
    case (state)
      lmfp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_accept) begin
          cnt_next = '0;
          case (in_action)
            lmfp_pkg::ACT_CLEAR: valid_clr = 1'b1;
            lmfp_pkg::ACT_LOAD: begin
              mem_we = (in_row_index < lmfp_pkg::IDX_W'(lmfp_pkg::ROWS));
              mem_wa = in_row_index;
              mem_wd = in_row_bits;
            end
            default: ;
          endcase
        end
      end
      lmfp_pkg::ST_RD_FIRST: rd_addr = cnt;
      lmfp_pkg::ST_GET_FIRST: begin
        capture_first = 1'b1;
        rd_addr       = cnt + 1'b1;
      end
      lmfp_pkg::ST_GET_SECOND: begin
        // Hold the read address so the second row stays put while the output stalls.
        rd_addr = cnt + 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          cnt_next = cnt + 2'd2;
        end
      end
      lmfp_pkg::ST_INV_RD: rd_addr = cnt;
      lmfp_pkg::ST_INV_WR: begin
        mem_we   = 1'b1;
        cnt_next = cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lmfp_pkg::ST_IDLE;
      cnt        <= '0;
      brightness <= lmfp_pkg::MAX_LEVEL;
      row_valid  <= '0;
      rd_ok      <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_wr_en) begin
        brightness <= (cfg_wr_data > lmfp_pkg::MAX_LEVEL) ? lmfp_pkg::MAX_LEVEL : cfg_wr_data;
      end
      if (valid_clr) begin
        row_valid <= '0;
      end else if (mem_we) begin
        row_valid[mem_wa[lmfp_pkg::ROW_AW-1:0]] <= 1'b1;
      end
      rd_ok <= (rd_addr < lmfp_pkg::IDX_W'(lmfp_pkg::ROWS)) &&
               row_valid[rd_addr[lmfp_pkg::ROW_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa[lmfp_pkg::ROW_AW-1:0]] <= mem_wd;
    end
    rd_data <= mem[rd_addr[lmfp_pkg::ROW_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (capture_first) begin
      first_code <= coded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {(lmfp_pkg::M_TDATA_W - lmfp_pkg::M_USED_W)'(0),
                       second_code, first_code, cnt, brightness};
      m_axis_tlast <= is_last_pair;
    end
  end

endmodule

`default_nettype wire

@@ design/lmfp_checker.sv @@
// Port-level checker of the LED matrix frame packer, bound to the top level.
// Uses lmfp_pkg and the assertion macros of led_matrix_frame_packer_macros.svh.
`default_nettype none
`include "led_matrix_frame_packer_macros.svh"

module lmfp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lmfp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic                           m_axis_tlast
);

  logic                           out_stall;
  logic                           last_pair_shown;
  logic [lmfp_pkg::CODE_W-1:0]    second_code;
  logic [lmfp_pkg::M_TDATA_W:0]   out_word;

  assign out_stall       = m_axis_tvalid && !m_axis_tready;
  assign last_pair_shown = m_axis_tvalid && (m_axis_tdata[4:2] == lmfp_pkg::LAST_PAIR_ROW);
  assign second_code     = m_axis_tdata[52:29];
  assign out_word        = {m_axis_tlast, m_axis_tdata};

  // A stalled message request keeps its contents.
  `LMFP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word))

  // Brightness is saturated on write, so the level never reaches three.
  `LMFP_ASSERT_NOW(a_level_range, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)

  // The lone last row closes the update and carries no second row.
  `LMFP_ASSERT_NOW(a_last_pair, last_pair_shown, m_axis_tlast && (second_code == '0))

  // Pair rows are even, and the padding of each first-row low byte is always set.
  `LMFP_ASSERT_NOW(a_pad_bits, m_axis_tvalid, !m_axis_tdata[2] && (m_axis_tdata[12:10] == 3'b111))

endmodule

bind led_matrix_frame_packer lmfp_checker u_lmfp_checker (.*);

`default_nettype wire
